// ===== sv/diff_drive_odometry_assert.svh =====
// ----------------------------------------------------------------------------
// diff_drive_odometry assertion macros
// shared property forms for the odometry block, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

// condition that holds at every edge out of reset
`define ODO_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition in the cycle after a trigger
`define ODO_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and tables of the odometry block
// ----------------------------------------------------------------------------
package odo_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int TRIG_ITERATIONS = 16;
	localparam int TURN_SHIFT      = 30 - FRAC_BITS;

	localparam logic [31:0] PI_Q30     = 32'd3373259426;
	localparam logic [31:0] GAIN_Q30   = 32'd652032874;
	localparam logic [31:0] LIN_SCALE  = 32'd1000000;
	localparam logic [31:0] TURN_SCALE = 32'd2000000;
	// ceil(2^33/3): floor(x/3) = (x * RECIP3_Q33) >> 33 for any 32-bit x
	localparam logic [31:0] RECIP3_Q33 = 32'hAAAA_AAAB;

	// shared divider: wide dividend, narrow divisor, a few quotient bits per cycle
	localparam int WIDE_W     = 128;
	localparam int DEN_W      = 48;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CYCLES = WIDE_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	// arctangent table, binary angle of a full turn
	localparam int ATAN_N  = 24;
	localparam int ATAN_IW = $clog2(ATAN_N);
	localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// step queue, depth a power of two
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [33:0] asum;
		logic        sum_neg;
		logic [33:0] adif;
		logic        dif_neg;
		logic [31:0] dt;
	} odo_step_t;

	typedef struct packed {
		logic full;
		logic empty;
	} odo_fifo_stat_t;

	typedef struct packed {
		logic [31:0] wheel_radius;
		logic [31:0] track_length;
		logic [15:0] ticks_per_rev;
	} odo_geom_t;

	typedef struct packed {
		logic        ld_x;
		logic        ld_y;
		logic        ld_h;
		logic [31:0] value;
	} odo_pose_load_t;

	typedef struct packed {
		logic busy;
	} odo_back_stat_t;

endpackage

// ===== sv/odo_in_if.sv =====
// ----------------------------------------------------------------------------
// odo_in_if
// encoder sample channel: valid, ready and the sample fields
// ----------------------------------------------------------------------------
interface odo_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] left_count;
	logic [31:0] right_count;
	logic [31:0] time_us;

	modport source (output valid, output left_count, output right_count,
		output time_us, input ready);
	modport sink (input valid, input left_count, input right_count,
		input time_us, output ready);
endinterface

// ===== sv/odo_out_if.sv =====
// ----------------------------------------------------------------------------
// odo_out_if
// pose result channel: valid, ready and the pose fields
// ----------------------------------------------------------------------------
interface odo_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] heading;
	logic [31:0] lin_speed;
	logic [31:0] turn_rate;

	modport source (output valid, output pos_x, output pos_y, output heading,
		output lin_speed, output turn_rate, input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading,
		input lin_speed, input turn_rate, output ready);
endinterface

// ===== sv/odo_fifo.sv =====
// ----------------------------------------------------------------------------
// odo_fifo
// short queue of classified steps between front and back
// ----------------------------------------------------------------------------
module odo_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  odo_pkg::odo_step_t         wr_data,
	input  logic                       pop,
	output odo_pkg::odo_step_t         rd_data,
	output odo_pkg::odo_fifo_stat_t    stat
);
	odo_pkg::odo_step_t             mem_q [odo_pkg::FIFO_DEPTH];
	logic [odo_pkg::FIFO_AW-1:0]    wp_q;
	logic [odo_pkg::FIFO_AW-1:0]    rp_q;
	logic [odo_pkg::FIFO_AW:0]      cnt_q;

	assign stat.full  = (cnt_q == (odo_pkg::FIFO_AW+1)'(odo_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= odo_pkg::FIFO_AW'(wp_q + 1'b1);
			if (pop) rp_q <= odo_pkg::FIFO_AW'(rp_q + 1'b1);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

// ===== sv/odo_front.sv =====
// ----------------------------------------------------------------------------
// odo_front
// takes samples, applies the interval test, forms signed tick sums and differences per step
// ----------------------------------------------------------------------------
module odo_front (
	input  logic                clk,
	input  logic                arst_n,
	odo_in_if.sink              sample,
	input  logic [31:0]         interval,
	input  logic [1:0]          reverse,
	input  logic                full,
	output logic                push,
	output odo_pkg::odo_step_t  step
);
	logic [31:0] last_left_q, last_right_q, last_time_q;
	logic [31:0] dt, dl, dr;
	logic [33:0] sl, sr, sum, dif;
	logic        upd;

	always_comb begin
		dt  = sample.time_us - last_time_q;
		dl  = sample.left_count - last_left_q;
		dr  = sample.right_count - last_right_q;
		upd = (dt > interval);
		sl  = reverse[0] ? 34'd0 - {2'b00, dl} : {2'b00, dl};
		sr  = reverse[1] ? 34'd0 - {2'b00, dr} : {2'b00, dr};
		sum = sr + sl;
		dif = sr - sl;
		step.sum_neg = sum[33];
		step.dif_neg = dif[33];
		step.asum    = sum[33] ? 34'd0 - sum : sum;
		step.adif    = dif[33] ? 34'd0 - dif : dif;
		step.dt      = dt;
	end

	assign sample.ready = !full;
	assign push = sample.valid && sample.ready && upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
			last_time_q  <= '0;
		end else if (push) begin
			last_left_q  <= sample.left_count;
			last_right_q <= sample.right_count;
			last_time_q  <= sample.time_us;
		end
	end
endmodule

// ===== sv/odo_div.sv =====
// ----------------------------------------------------------------------------
// odo_div
// restoring divider, wide dividend by narrow divisor, few bits per cycle
// ----------------------------------------------------------------------------
module odo_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [odo_pkg::WIDE_W-1:0]    num,
	input  logic [odo_pkg::DEN_W-1:0]     den,
	output logic                          done,
	output logic [odo_pkg::WIDE_W-1:0]    quo
);
	logic                             run_q, done_q;
	logic [odo_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [odo_pkg::WIDE_W-1:0]       n_q, n_nx;
	logic [odo_pkg::DEN_W-1:0]        rem_q, r_nx, d_q;

	always_comb begin
		logic [odo_pkg::DEN_W:0] sh;
		r_nx = rem_q;
		n_nx = n_q;
		sh   = '0;
		for (int k = 0; k < odo_pkg::DIV_STEPS; k++) begin
			sh   = {r_nx, n_nx[odo_pkg::WIDE_W-1]};
			n_nx = {n_nx[odo_pkg::WIDE_W-2:0], 1'b0};
			if (sh >= {1'b0, d_q}) begin
				r_nx    = odo_pkg::DEN_W'(sh - {1'b0, d_q});
				n_nx[0] = 1'b1;
			end else begin
				r_nx = sh[odo_pkg::DEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// zero divisor answers at once
				if (den == '0) done_q <= 1'b1;
				else run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == odo_pkg::DIV_CNT_W'(odo_pkg::DIV_CYCLES-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (den == '0) n_q <= (num != '0) ? '1 : '0;
			else n_q <= num;
			rem_q <= '0;
			d_q   <= den;
		end else if (run_q) begin
			n_q   <= n_nx;
			rem_q <= r_nx;
		end
	end
endmodule

// ===== sv/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation cordic, cos and sin in Q2.30 of a binary angle
// ----------------------------------------------------------------------------
module odo_cordic (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [31:0]  angle,
	output logic         done,
	output logic [31:0]  cos_q30,
	output logic [31:0]  sin_q30
);
	localparam logic signed [33:0] ONE = 34'sh0_4000_0000;

	logic                          run_q, done_q, flip_q;
	logic [odo_pkg::ATAN_IW-1:0]   i_q;
	logic signed [33:0]            x_q, y_q, z_q;
	logic signed [33:0]            za, z0, xs, ys, at;
	logic                          flip0;

	function automatic logic [31:0] clamp(input logic signed [33:0] v, input logic neg);
		logic signed [33:0] c;
		if (v > ONE) c = ONE;
		else if (v < -ONE) c = -ONE;
		else c = v;
		if (neg) c = -c;
		return c[31:0];
	endfunction

	always_comb begin
		za    = {{2{angle[31]}}, angle};
		flip0 = 1'b0;
		z0    = za;
		// fold into the right half plane
		if (za > ONE) begin
			z0    = za - (ONE <<< 1);
			flip0 = 1'b1;
		end else if (za < -ONE) begin
			z0    = za + (ONE <<< 1);
			flip0 = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = {2'b00, odo_pkg::ATAN_TURNS[i_q]};
	end

	assign done    = done_q;
	assign cos_q30 = clamp(x_q, flip_q);
	assign sin_q30 = clamp(y_q, flip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (i_q == odo_pkg::ATAN_IW'(odo_pkg::TRIG_ITERATIONS-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= {2'b00, odo_pkg::GAIN_Q30};
			y_q    <= '0;
			z_q    <= z0;
			flip_q <= flip0;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end
endmodule

// ===== sv/odo_back.sv =====
// ----------------------------------------------------------------------------
// odo_back
// step sequencer: shared multiplier, divider and cordic, pose and result beat
// ----------------------------------------------------------------------------
module odo_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fifo_empty,
	input  odo_pkg::odo_step_t         entry,
	output logic                       pop,
	input  odo_pkg::odo_geom_t         geom,
	input  odo_pkg::odo_pose_load_t    pose_load,
	odo_out_if.source                  pose,
	output odo_pkg::odo_back_stat_t    stat
);
	localparam int MUL_CHUNKS = odo_pkg::WIDE_W / 32;
	localparam int MUL_CW     = $clog2(MUL_CHUNKS + 1);
	localparam int W          = odo_pkg::WIDE_W;

	typedef enum logic [22:0] {
		ST_IDLE = 23'h000001, ST_AR   = 23'h000002, ST_ARP  = 23'h000004,
		ST_N1   = 23'h000008, ST_DEN  = 23'h000010, ST_LIN  = 23'h000020,
		ST_DR   = 23'h000040, ST_DRP  = 23'h000080, ST_N2   = 23'h000100,
		ST_TQ1  = 23'h000200, ST_TQ2  = 23'h000400, ST_AQ1  = 23'h000800,
		ST_AQ2  = 23'h001000, ST_BASE = 23'h002000, ST_COS1 = 23'h004000,
		ST_COS2 = 23'h008000, ST_FXM  = 23'h010000, ST_FXD  = 23'h020000,
		ST_FYM  = 23'h040000, ST_FYD  = 23'h080000, ST_DX   = 23'h100000,
		ST_DY   = 23'h200000, ST_OUT  = 23'h400000
	} state_t;

	state_t state_q, state_nx;
	logic   issued_q;

	odo_pkg::odo_step_t step_q;
	logic [65:0]  ar_q, dr_q;
	logic [97:0]  arp_q;
	logic [W-1:0] w_q;
	logic [47:0]  den_q;
	logic [91:0]  base_q;
	logic [31:0]  lin_q, turn_q, inc_q, half_q, g_q, cs_q, sn_q, dx_q, dy_q;
	logic [30:0]  fxm_q, fym_q;
	logic         fx_neg_q, fy_neg_q;
	logic [31:0]  cur_x_q, cur_y_q, cur_h_q;
	logic         out_valid_q;
	logic [31:0]  ox_q, oy_q, oh_q, olin_q, oturn_q;

	// multiplier: wide by 32 bits, one 32x32 chunk per cycle, high chunk first
	logic              mul_go, mul_run_q, mul_fin_q;
	logic [MUL_CW-1:0] mul_cnt_q;
	logic [W-1:0]      mul_a, mul_a_q, mul_acc_q;
	logic [31:0]       mul_b, mul_b_q;
	logic [63:0]       pp_c, pp_s1;

	logic               div_go, div_done;
	logic [W-1:0]       div_num, div_quo;
	logic [47:0]        div_den;
	logic               cor_go, cor_done;
	logic [31:0]        cor_ang, cor_cos, cor_sin;
	logic               need_mul, need_div, need_cor, op_done;
	logic [31:0]        cs_abs, sn_abs, dx_raw, dy_raw;

	function automatic logic [31:0] sat32(input logic [W-1:0] m, input logic neg);
		if (neg) begin
			if (m > W'(32'h8000_0000)) return 32'h8000_0000;
			return 32'd0 - m[31:0];
		end
		if (m > W'(32'h7FFF_FFFF)) return 32'h7FFF_FFFF;
		return m[31:0];
	endfunction

	odo_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	odo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_go), .angle(cor_ang),
		.done(cor_done), .cos_q30(cor_cos), .sin_q30(cor_sin)
	);

	assign cs_abs = cs_q[31] ? 32'd0 - cs_q : cs_q;
	assign sn_abs = sn_q[31] ? 32'd0 - sn_q : sn_q;
	assign dx_raw = mul_acc_q[91:60];
	assign dy_raw = mul_acc_q[91:60];
	assign pp_c   = mul_a_q[W-1:W-32] * mul_b_q;

	// operand routing per step
	always_comb begin
		need_mul = 1'b0;
		need_div = 1'b0;
		need_cor = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		div_num  = '0;
		div_den  = '0;
		cor_ang  = '0;
		case (state_q)
			ST_AR: begin
				need_mul = 1'b1; mul_a = W'(step_q.asum); mul_b = geom.wheel_radius;
			end
			ST_ARP: begin
				need_mul = 1'b1; mul_a = W'(ar_q); mul_b = odo_pkg::PI_Q30;
			end
			ST_N1: begin
				need_mul = 1'b1; mul_a = W'(arp_q); mul_b = odo_pkg::LIN_SCALE;
			end
			ST_DEN: begin
				need_mul = 1'b1; mul_a = W'(step_q.dt); mul_b = 32'(geom.ticks_per_rev);
			end
			ST_LIN: begin
				need_div = 1'b1; div_num = w_q; div_den = den_q;
			end
			ST_DR: begin
				need_mul = 1'b1; mul_a = W'(step_q.adif); mul_b = geom.wheel_radius;
			end
			ST_DRP: begin
				need_mul = 1'b1; mul_a = W'(dr_q); mul_b = odo_pkg::PI_Q30;
			end
			ST_N2: begin
				need_mul = 1'b1; mul_a = w_q; mul_b = odo_pkg::TURN_SCALE;
			end
			ST_TQ1: begin
				need_div = 1'b1; div_num = w_q; div_den = den_q;
			end
			ST_TQ2, ST_AQ2: begin
				need_div = 1'b1; div_num = w_q; div_den = 48'(geom.track_length);
			end
			ST_AQ1: begin
				need_div = 1'b1; div_num = W'({dr_q, 32'd0});
				div_den = 48'(geom.ticks_per_rev);
			end
			ST_BASE: begin
				need_div = 1'b1; div_num = W'(arp_q); div_den = 48'(geom.ticks_per_rev);
			end
			ST_COS1: begin
				need_cor = 1'b1; cor_ang = half_q;
			end
			ST_COS2: begin
				need_cor = 1'b1; cor_ang = cur_h_q + half_q;
			end
			ST_FXM: begin
				need_mul = 1'b1; mul_a = W'(g_q); mul_b = cs_abs;
			end
			ST_FYM: begin
				need_mul = 1'b1; mul_a = W'(g_q); mul_b = sn_abs;
			end
			// divide by 3*2^30: drop 30 bits, then reciprocal multiply by three
			ST_FXD, ST_FYD: begin
				need_mul = 1'b1; mul_a = W'(w_q[61:30]); mul_b = odo_pkg::RECIP3_Q33;
			end
			ST_DX: begin
				need_mul = 1'b1; mul_a = W'(base_q); mul_b = 32'(fxm_q);
			end
			ST_DY: begin
				need_mul = 1'b1; mul_a = W'(base_q); mul_b = 32'(fym_q);
			end
			default: ;
		endcase
	end

	assign mul_go  = need_mul && !issued_q;
	assign div_go  = need_div && !issued_q;
	assign cor_go  = need_cor && !issued_q;
	assign op_done = mul_fin_q || div_done || cor_done;
	assign pop     = (state_q == ST_IDLE) && !fifo_empty;
	assign stat.busy = (state_q != ST_IDLE);

	always_comb begin
		case (state_q)
			ST_IDLE: state_nx = ST_AR;
			ST_AR:   state_nx = ST_ARP;
			ST_ARP:  state_nx = ST_N1;
			ST_N1:   state_nx = ST_DEN;
			ST_DEN:  state_nx = ST_LIN;
			ST_LIN:  state_nx = ST_DR;
			ST_DR:   state_nx = ST_DRP;
			ST_DRP:  state_nx = ST_N2;
			ST_N2:   state_nx = ST_TQ1;
			ST_TQ1:  state_nx = ST_TQ2;
			ST_TQ2:  state_nx = ST_AQ1;
			ST_AQ1:  state_nx = ST_AQ2;
			ST_AQ2:  state_nx = ST_BASE;
			ST_BASE: state_nx = ST_COS1;
			ST_COS1: state_nx = ST_COS2;
			ST_COS2: state_nx = ST_FXM;
			ST_FXM:  state_nx = ST_FXD;
			ST_FXD:  state_nx = ST_FYM;
			ST_FYM:  state_nx = ST_FYD;
			ST_FYD:  state_nx = ST_DX;
			ST_DX:   state_nx = ST_DY;
			ST_DY:   state_nx = ST_OUT;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_h_q     <= '0;
		end else begin
			if (out_valid_q && pose.ready) out_valid_q <= 1'b0;
			if (mul_go || div_go || cor_go) issued_q <= 1'b1;
			if (pose_load.ld_x) cur_x_q <= pose_load.value;
			if (pose_load.ld_y) cur_y_q <= pose_load.value;
			if (pose_load.ld_h) cur_h_q <= pose_load.value;
			case (state_q)
				ST_IDLE: begin
					if (!fifo_empty) state_q <= state_nx;
				end
				ST_OUT: begin
					if (!out_valid_q || pose.ready) begin
						cur_x_q     <= cur_x_q + dx_q;
						cur_y_q     <= cur_y_q + dy_q;
						cur_h_q     <= cur_h_q + inc_q;
						out_valid_q <= 1'b1;
						state_q     <= state_nx;
					end
				end
				default: begin
					if (op_done) begin
						issued_q <= 1'b0;
						state_q  <= state_nx;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q <= 1'b0;
			mul_fin_q <= 1'b0;
			mul_cnt_q <= '0;
		end else begin
			mul_fin_q <= 1'b0;
			if (mul_go) begin
				mul_run_q <= 1'b1;
				mul_cnt_q <= '0;
			end else if (mul_run_q) begin
				if (mul_cnt_q == MUL_CW'(MUL_CHUNKS)) begin
					mul_run_q <= 1'b0;
					mul_fin_q <= 1'b1;
				end
				mul_cnt_q <= mul_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mul_a_q   <= mul_a;
			mul_b_q   <= mul_b;
			mul_acc_q <= '0;
		end else if (mul_run_q) begin
			if (mul_cnt_q != MUL_CW'(MUL_CHUNKS)) begin
				pp_s1   <= pp_c;
				mul_a_q <= mul_a_q << 32;
			end
			if (mul_cnt_q != '0) mul_acc_q <= (mul_acc_q << 32) + W'(pp_s1);
		end
	end

	// captures of each step result
	always_ff @(posedge clk) begin
		if (pop) step_q <= entry;
		if (op_done) begin
			case (state_q)
				ST_AR:   ar_q  <= mul_acc_q[65:0];
				ST_ARP:  arp_q <= mul_acc_q[97:0];
				ST_N1:   w_q   <= mul_acc_q;
				ST_DEN:  den_q <= mul_acc_q[47:0];
				ST_LIN:  lin_q <= sat32(div_quo >> 30, step_q.sum_neg);
				ST_DR:   dr_q  <= mul_acc_q[65:0];
				ST_DRP:  w_q   <= mul_acc_q;
				ST_N2:   w_q   <= mul_acc_q;
				ST_TQ1:  w_q   <= div_quo;
				ST_TQ2:  turn_q <= sat32(div_quo >> odo_pkg::TURN_SHIFT, step_q.dif_neg);
				ST_AQ1:  w_q   <= div_quo;
				ST_AQ2: begin
					inc_q  <= step_q.dif_neg ? 32'd0 - div_quo[31:0] : div_quo[31:0];
					half_q <= step_q.dif_neg ? 32'd0 - div_quo[32:1] : div_quo[32:1];
				end
				ST_BASE: base_q <= div_quo[91:0];
				ST_COS1: g_q <= 32'h8000_0000 + cor_cos;
				ST_COS2: begin
					cs_q     <= cor_cos;
					sn_q     <= cor_sin;
					fx_neg_q <= cor_cos[31];
					fy_neg_q <= cor_sin[31];
				end
				ST_FXM:  w_q   <= mul_acc_q;
				ST_FXD:  fxm_q <= mul_acc_q[63:33];
				ST_FYM:  w_q   <= mul_acc_q;
				ST_FYD:  fym_q <= mul_acc_q[63:33];
				ST_DX:   dx_q  <= (step_q.sum_neg ^ fx_neg_q) ? 32'd0 - dx_raw : dx_raw;
				ST_DY:   dy_q  <= (step_q.sum_neg ^ fy_neg_q) ? 32'd0 - dy_raw : dy_raw;
				default: ;
			endcase
		end
		if ((state_q == ST_OUT) && (!out_valid_q || pose.ready)) begin
			ox_q    <= cur_x_q + dx_q;
			oy_q    <= cur_y_q + dy_q;
			oh_q    <= cur_h_q + inc_q;
			olin_q  <= lin_q;
			oturn_q <= turn_q;
		end
	end

	assign pose.valid     = out_valid_q;
	assign pose.pos_x     = ox_q;
	assign pose.pos_y     = oy_q;
	assign pose.heading   = oh_q;
	assign pose.lin_speed = olin_q;
	assign pose.turn_rate = oturn_q;
endmodule

// ===== sv/diff_drive_odometry.sv =====
// Differential drive odometry. Each sample beat carries left and right encoder
// counts and a microsecond time stamp. A sample whose elapsed time since the
// last update is not above update_interval_us is accepted and gives
// no result; such samples stream at one per cycle while the step queue has
// room. An updating sample gives one pose beat (x, y, heading, linear speed,
// turn rate) after the back end runs six 128-bit divisions through one shared
// divider at two quotient bits per cycle, thirteen wide multiplications at
// one 32x32 chunk per cycle (the two divides by three among them as
// reciprocal products) and two 16-step cordic runs.
// Writes to start_x, start_y or start_heading also load the current
// pose; write configuration only while the block is idle.
// ----------------------------------------------------------------------------
// diff_drive_odometry
// top level: configuration registers, front, step queue and back end
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_assert.svh"

module diff_drive_odometry (
	input  logic         clk,
	input  logic         arst_n,
	odo_in_if.sink       sample,
	odo_out_if.source    pose,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata
);
	// register map
	typedef enum logic [2:0] {
		CFG_WHEEL_RADIUS  = 3'd0,
		CFG_TRACK_LENGTH  = 3'd1,
		CFG_TICKS_PER_REV = 3'd2,
		CFG_INTERVAL      = 3'd3,
		CFG_WHEEL_REVERSE = 3'd4,
		CFG_START_X       = 3'd5,
		CFG_START_Y       = 3'd6,
		CFG_START_HEADING = 3'd7
	} cfg_reg_e;

	odo_pkg::odo_geom_t       geom_q;
	logic [31:0]              interval_q;
	logic [1:0]               reverse_q;
	odo_pkg::odo_pose_load_t  pose_load;

	odo_pkg::odo_step_t       push_step, pop_step;
	odo_pkg::odo_fifo_stat_t  fifo_stat;
	odo_pkg::odo_back_stat_t  back_stat;
	logic                     push, pop;

	// start registers are only ever seen through the pose they load
	always_comb begin
		pose_load.ld_x  = 1'b0;
		pose_load.ld_y  = 1'b0;
		pose_load.ld_h  = 1'b0;
		pose_load.value = cfg_wdata;
		if (cfg_wen) begin
			case (cfg_reg_e'(cfg_idx))
				CFG_START_X:       pose_load.ld_x = 1'b1;
				CFG_START_Y:       pose_load.ld_y = 1'b1;
				CFG_START_HEADING: pose_load.ld_h = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.wheel_radius  <= 32'd65536;
			geom_q.track_length  <= 32'd65536;
			geom_q.ticks_per_rev <= 16'd360;
			interval_q           <= 32'd50000;
			reverse_q            <= 2'd0;
		end else if (cfg_wen) begin
			case (cfg_reg_e'(cfg_idx))
				CFG_WHEEL_RADIUS:  geom_q.wheel_radius  <= cfg_wdata;
				CFG_TRACK_LENGTH:  geom_q.track_length  <= cfg_wdata;
				CFG_TICKS_PER_REV: geom_q.ticks_per_rev <= cfg_wdata[15:0];
				CFG_INTERVAL:      interval_q           <= cfg_wdata;
				CFG_WHEEL_REVERSE: reverse_q            <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// front: interval test and tick differences, one sample per cycle while the queue has room
	odo_front u_front (
		.clk(clk), .arst_n(arst_n), .sample(sample), .interval(interval_q),
		.reverse(reverse_q), .full(fifo_stat.full), .push(push), .step(push_step)
	);

	// queue lets the front keep taking samples while the back end works
	odo_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_data(push_step),
		.pop(pop), .rd_data(pop_step), .stat(fifo_stat)
	);

	// back: speeds, turn angle, cordic, pose update and result register
	odo_back u_back (
		.clk(clk), .arst_n(arst_n), .fifo_empty(fifo_stat.empty),
		.entry(pop_step), .pop(pop), .geom(geom_q), .pose_load(pose_load),
		.pose(pose), .stat(back_stat)
	);

	`ODO_ASSERT_HOLDS(a_no_push_full, !(push && fifo_stat.full), "step pushed into full queue")
	`ODO_ASSERT_HOLDS(a_no_pop_empty, !(pop && fifo_stat.empty), "step popped from empty queue")
	`ODO_ASSERT_NEXT(a_pop_busy, pop, back_stat.busy, "back end idle after taking a step")
endmodule

// ===== test/tb_diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry
// self-checking bench for the differential drive odometry block: encoder
// samples go in through the valid/ready channel, a bit-exact fixed point
// pose predictor in a scoreboard class produces the expected pose beats,
// and every pose beat is compared field by field
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry;

	typedef enum logic [2:0] {
		REG_RADIUS   = 3'd0,
		REG_TRACK    = 3'd1,
		REG_TICKS    = 3'd2,
		REG_INTERVAL = 3'd3,
		REG_REVERSE  = 3'd4,
		REG_START_X  = 3'd5,
		REG_START_Y  = 3'd6,
		REG_START_H  = 3'd7
	} odo_reg_e;

	typedef logic [127:0] wide_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] heading;
		logic [31:0] lin_speed;
		logic [31:0] turn_rate;
	} pose_beat_t;

	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam int     DRAIN_CYCLES = 800;
	localparam int     HOLD_CYCLES  = 2500;

	// scoreboard: fixed point odometry predictor and the queue of pending poses
	class odo_scoreboard;
		logic [31:0] radius, track, interval, start_x, start_y, start_h;
		logic [15:0] ticks;
		logic [1:0]  reverse;
		logic [31:0] last_l, last_r, last_t, cur_x, cur_y, cur_h;
		pose_beat_t  pending[$];
		int          mismatches;

		function new();
			radius = 32'd65536; track = 32'd65536; ticks = 16'd360;
			interval = 32'd50000; reverse = 2'd0;
			start_x = '0; start_y = '0; start_h = '0;
			last_l = '0; last_r = '0; last_t = '0;
			cur_x = '0; cur_y = '0; cur_h = '0;
			mismatches = 0;
		endfunction

		function void write_reg(odo_reg_e idx, logic [31:0] v);
			case (idx)
				REG_RADIUS:   radius = v;
				REG_TRACK:    track = v;
				REG_TICKS:    ticks = v[15:0];
				REG_INTERVAL: interval = v;
				REG_REVERSE:  reverse = v[1:0];
				REG_START_X: begin start_x = v; cur_x = v; end
				REG_START_Y: begin start_y = v; cur_y = v; end
				REG_START_H: begin start_h = v; cur_h = v; end
				default: ;
			endcase
		endfunction

		// divide by zero gives all ones unless the dividend is zero
		function wide_t qdiv(wide_t n, wide_t d);
			if (d == 0)
				return (n != 0) ? {128{1'b1}} : '0;
			return n / d;
		endfunction

		function logic [31:0] saturate(wide_t m, bit neg);
			if (neg)
				return (m > 128'h8000_0000) ? 32'h8000_0000 : -m[31:0];
			return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		endfunction

		// cordic in Q2.30 over a binary angle, folded into the right half plane
		function void trig(logic [31:0] ang, output longint c, output longint s);
			longint z, x, y, xs, ys;
			bit     flip;
			z = longint'({32'b0, ang});
			x = longint'({32'b0, odo_pkg::GAIN_Q30});
			y = 0;
			flip = 0;
			if (ang[31])
				z -= 64'sh1_0000_0000;
			if (z > ONE_Q30) begin
				z -= 2 * ONE_Q30; flip = 1;
			end else if (z < -ONE_Q30) begin
				z += 2 * ONE_Q30; flip = 1;
			end
			for (int i = 0; i < odo_pkg::TRIG_ITERATIONS && i < odo_pkg::ATAN_N; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= longint'({32'b0, odo_pkg::ATAN_TURNS[i]});
				end else begin
					x += ys; y -= xs; z += longint'({32'b0, odo_pkg::ATAN_TURNS[i]});
				end
			end
			if (x > ONE_Q30) x = ONE_Q30;
			if (x < -ONE_Q30) x = -ONE_Q30;
			if (y > ONE_Q30) y = ONE_Q30;
			if (y < -ONE_Q30) y = -ONE_Q30;
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function logic [31:0] displacement(wide_t base, longint f, bit neg_dist);
			wide_t       p;
			logic [31:0] low;
			p = base * wide_t'(f < 0 ? -f : f);
			low = p[91:60];
			return (neg_dist != (f < 0)) ? -low : low;
		endfunction

		// one accepted encoder beat; queues a pose when an update is due
		function void note_sample(logic [31:0] left, logic [31:0] right, logic [31:0] now);
			logic [31:0] dt, inc, half;
			longint      sl, sr, sum, dif, c1, s1, cs, sn, g, fx, fy;
			wide_t       asum, adif, den, w, q, base;
			pose_beat_t  b;
			dt = now - last_t;
			if (!(dt > interval))
				return;
			sl = longint'({32'b0, left - last_l});
			sr = longint'({32'b0, right - last_r});
			if (reverse[0]) sl = -sl;
			if (reverse[1]) sr = -sr;
			sum = sr + sl;
			dif = sr - sl;
			asum = wide_t'(sum < 0 ? -sum : sum);
			adif = wide_t'(dif < 0 ? -dif : dif);
			den = wide_t'(ticks) * wide_t'(dt);

			w = asum * radius; w = w * odo_pkg::PI_Q30; w = w * odo_pkg::LIN_SCALE;
			b.lin_speed = saturate(qdiv(w, den) >> 30, sum < 0);

			w = adif * radius; w = w * odo_pkg::PI_Q30; w = w * odo_pkg::TURN_SCALE;
			b.turn_rate = saturate(qdiv(qdiv(w, den), track) >> odo_pkg::TURN_SHIFT,
				dif < 0);

			// turn angle of this step and its half, as binary angles
			w = adif * radius;
			q = qdiv(qdiv(w << 32, ticks), track);
			inc = q[31:0];
			half = q[32:1];
			if (dif < 0) begin
				inc = -inc; half = -half;
			end

			trig(half, c1, s1);
			trig(cur_h + half, cs, sn);
			g = 2 * ONE_Q30 + c1;
			fx = (g * cs) / (3 * ONE_Q30);
			fy = (g * sn) / (3 * ONE_Q30);

			w = asum * radius; w = w * odo_pkg::PI_Q30;
			base = qdiv(w, ticks);
			cur_x += displacement(base, fx, sum < 0);
			cur_y += displacement(base, fy, sum < 0);
			cur_h += inc;
			last_l = left; last_r = right; last_t = now;

			b.pos_x = cur_x; b.pos_y = cur_y; b.heading = cur_h;
			pending.push_back(b);
		endfunction

		function void check_pose(pose_beat_t got);
			pose_beat_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pose beat x=%h y=%h h=%h v=%h w=%h",
						got.pos_x, got.pos_y, got.heading, got.lin_speed, got.turn_rate);
				return;
			end
			e = pending.pop_front();
			if (got != e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pose mismatch exp x=%h y=%h h=%h v=%h w=%h got x=%h y=%h h=%h v=%h w=%h",
						e.pos_x, e.pos_y, e.heading, e.lin_speed, e.turn_rate,
						got.pos_x, got.pos_y, got.heading, got.lin_speed, got.turn_rate);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	odo_in_if  enc_ch();
	odo_out_if pose_ch();

	diff_drive_odometry i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (enc_ch),
		.pose      (pose_ch),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	odo_scoreboard sb;

	// running encoder counts and time of the stimulus side
	logic [31:0] left_now, right_now, time_now;
	bit          send_idle_on, recv_idle_on;
	bit          hold_done;
	int          poses_seen;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// hard stop for a hung handshake
	initial begin
		#(20 * 6_000_000);
		$display("Some tests failed");
		$finish;
	end

	task automatic write_cfg(odo_reg_e idx, logic [31:0] v);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_idx = idx;
		cfg_wdata = v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	// one encoder beat: optional idle gap, then hold valid until accepted
	task automatic send_encoder(logic [31:0] l, logic [31:0] r, logic [31:0] t);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 8) : 0;
		repeat (gap) @(negedge clk);
		enc_ch.valid = 1'b1;
		enc_ch.left_count = l;
		enc_ch.right_count = r;
		enc_ch.time_us = t;
		do @(posedge clk); while (!enc_ch.ready);
		sb.note_sample(l, r, t);
		@(negedge clk);
		enc_ch.valid = 1'b0;
	endtask

	// advance counts and time by the given deltas and send the beat
	task automatic step_robot(logic [31:0] dl, logic [31:0] dr, logic [31:0] dtm);
		left_now += dl;
		right_now += dr;
		time_now += dtm;
		send_encoder(left_now, right_now, time_now);
	endtask

	// wait for every pending pose, then let the back end go quiet
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(logic [31:0] r, logic [31:0] l, logic [15:0] t,
		logic [31:0] iv, logic [1:0] rev);
		write_cfg(REG_RADIUS, r);
		write_cfg(REG_TRACK, l);
		write_cfg(REG_TICKS, {16'b0, t});
		write_cfg(REG_INTERVAL, iv);
		write_cfg(REG_REVERSE, {30'b0, rev});
		write_cfg(REG_START_X, $urandom());
		write_cfg(REG_START_Y, $urandom());
		write_cfg(REG_START_H, $urandom());
	endtask

	// small signed tick delta, mostly realistic wheel motion
	function automatic logic [31:0] tick_delta();
		case ($urandom_range(0, 9))
			0:       return $urandom();
			1:       return 32'd0;
			default: return $urandom_range(0, 4000) - 2000;
		endcase
	endfunction

	// random beats: mostly well-formed motion past the interval, some noise
	task automatic random_beats(int n);
		logic [63:0] iv;
		logic [31:0] dtm;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				send_idle_on = $urandom_range(0, 2) != 0;
			iv = {32'b0, sb.interval};
			if ($urandom_range(0, 9) == 0) begin
				// noise: anything at all, time jumps included
				left_now = $urandom(); right_now = $urandom();
				time_now = $urandom();
				send_encoder(left_now, right_now, time_now);
			end else begin
				if ($urandom_range(0, 9) < 7 && iv != 64'hFFFF_FFFF)
					dtm = 32'(iv + 64'd1 + 64'($urandom_range(0, 3000)));
				else
					dtm = (iv == 0) ? 32'd0 : 32'(64'($urandom()) % (iv + 64'd1));
				step_robot(tick_delta(), tick_delta(), dtm);
			end
		end
	endtask

	// pose side: random ready gaps, one long hold so the input backs up
	initial begin
		pose_beat_t got;
		pose_ch.ready = 1'b0;
		poses_seen = 0;
		hold_done = 0;
		recv_idle_on = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && poses_seen == 20) begin
				hold_done = 1;
				pose_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (poses_seen % 50 == 0)
					recv_idle_on = $urandom_range(0, 2) != 0;
				if (recv_idle_on) begin
					pose_ch.ready = 1'b0;
					repeat ($urandom_range(0, 8)) @(negedge clk);
				end
			end
			pose_ch.ready = 1'b1;
			do @(posedge clk); while (!pose_ch.valid);
			got.pos_x = pose_ch.pos_x;
			got.pos_y = pose_ch.pos_y;
			got.heading = pose_ch.heading;
			got.lin_speed = pose_ch.lin_speed;
			got.turn_rate = pose_ch.turn_rate;
			sb.check_pose(got);
			poses_seen++;
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = REG_RADIUS;
		cfg_wdata = '0;
		enc_ch.valid = 1'b0;
		enc_ch.left_count = '0;
		enc_ch.right_count = '0;
		enc_ch.time_us = '0;
		left_now = '0; right_now = '0; time_now = '0;
		send_idle_on = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: 360 ticks, 1 m wheel and track, 50 ms
		step_robot(0, 0, 32'd50000);                   // exactly the interval: no update
		step_robot(0, 0, 32'd1);                       // just past it, standing still
		step_robot(32'd100, 32'd100, 32'd50001);       // straight ahead
		step_robot(-32'd100, -32'd100, 32'd60000);     // straight back
		step_robot(-32'd90, 32'd90, 32'd60000);        // spin left
		step_robot(32'd90, -32'd90, 32'd60000);        // spin right
		step_robot(32'd1, 32'd0, 32'd100000);          // gentle right arc
		step_robot(32'h7FFF_FFFF, 32'h8000_0000, 32'd50001); // huge ticks, saturating speed
		step_robot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd50001); // counter wrap, one back tick
		step_robot(32'd5, 32'd7, 32'hFFFF_0000);       // time stamp wraps
		send_encoder(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		send_encoder(32'h0, 32'hFFFF_FFFF, 32'h0);     // elapsed time of one
		left_now = 32'h0; right_now = 32'hFFFF_FFFF; time_now = 32'h0;
		step_robot(32'd10, 32'd10, 32'd10);            // short gap ignored
		drain();

		// smallest geometry, no interval, left wheel reversed, extreme start pose
		write_cfg(REG_RADIUS, 32'd1);
		write_cfg(REG_TRACK, 32'd1);
		write_cfg(REG_TICKS, 32'd1);
		write_cfg(REG_INTERVAL, 32'd0);
		write_cfg(REG_REVERSE, 32'd1);
		write_cfg(REG_START_X, 32'h8000_0000);
		write_cfg(REG_START_Y, 32'h7FFF_FFFF);
		write_cfg(REG_START_H, 32'hFFFF_FFFF);
		step_robot(0, 0, 0);                           // zero elapsed time
		random_beats(250);
		drain();

		// largest geometry, right wheel reversed
		load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd1000, 2'd2);
		random_beats(230);
		drain();

		// zero ticks per turn and zero track: divide by zero path
		load_setting(32'd6554, 32'd0, 16'd0, 32'd500, 2'd3);
		random_beats(120);
		drain();
		load_setting(32'd6554, 32'd32768, 16'd0, 32'd500, 2'd0);
		random_beats(60);
		drain();
		load_setting(32'd6554, 32'd0, 16'd360, 32'd500, 2'd1);
		random_beats(60);
		drain();

		// longest interval: nothing ever updates
		load_setting(32'd65536, 32'd65536, 16'd360, 32'hFFFF_FFFF, 2'd0);
		random_beats(20);
		drain();

		// realistic robots
		for (int p = 0; p < 4; p++) begin
			load_setting($urandom_range(1000, 20000), $urandom_range(5000, 80000),
				16'($urandom_range(20, 4096)), $urandom_range(0, 100000),
				2'($urandom_range(0, 3)));
			random_beats(270);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
